FILE: src/spmf_pkg.sv
`timescale 1ns / 1ps
// Package for the strict-priority multilevel queue: sizes, codes and widths.
// Used by the channel interfaces and by the queue module; spmf_ram does not use it.
package spmf_pkg;

	localparam int LEVELS      = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int ID_BITS     = 16;

	// Fixed field widths of the channels
	localparam int CMD_W = 1;
	localparam int PRI_W = 4;
	localparam int ID_W  = 16;
	localparam int ST_W  = 2;

	// Derived sizes
	localparam int TAG_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int SUM_W  = SLOT_W + 1;
	localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LVL_W-1:0]  lvl_t;

endpackage

FILE: src/spmf_in_if.sv
`timescale 1ns / 1ps
// Command channel of the priority queue: valid/ready plus one command beat.
// Depends on spmf_pkg for field widths.
interface spmf_in_if;
	logic                        valid;
	logic                        ready;
	logic [spmf_pkg::CMD_W-1:0]  command;
	logic [spmf_pkg::PRI_W-1:0]  priority_req;
	logic [spmf_pkg::ID_W-1:0]   entry_id;

	modport source (output valid, output command, output priority_req, output entry_id,
		input ready);
	modport sink (input valid, input command, input priority_req, input entry_id,
		output ready);
endinterface

FILE: src/spmf_out_if.sv
`timescale 1ns / 1ps
// Result channel of the priority queue: valid/ready plus one result beat.
// Depends on spmf_pkg for field widths.
interface spmf_out_if;
	logic                        valid;
	logic                        ready;
	logic [spmf_pkg::ST_W-1:0]   status;
	logic [spmf_pkg::ID_W-1:0]   popped_id;
	logic [spmf_pkg::PRI_W-1:0]  popped_priority;
	logic                        all_empty;

	modport source (output valid, output status, output popped_id,
		output popped_priority, output all_empty, input ready);
	modport sink (input valid, input status, input popped_id,
		input popped_priority, input all_empty, output ready);
endinterface

FILE: src/spmf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/strict_priority_multilevel_fifo.sv
`timescale 1ns / 1ps
// Strict-priority multilevel queue. One FIFO ring per priority level 1..LEVELS shares a
// single entry-tag RAM; per-level counts and head pointers sit in flip-flops. A push
// appends a tag to its level (refused when full or when the level is out of range); a pop
// takes the oldest tag of the highest non-empty level. Every command beat yields exactly
// one result beat. One command is accepted per cycle while stage 1 is free or advancing;
// its result passes the registered read of the tag RAM (stage 1) and then the output
// register, which lets a new command enter while a result waits to be taken.
// Depends on spmf_pkg, spmf_in_if, spmf_out_if and spmf_ram.
module strict_priority_multilevel_fifo (
	input  logic       clk,
	input  logic       arst_n,
	spmf_in_if.sink    req,
	spmf_out_if.source rsp
);

	// Per-level state
	spmf_pkg::cnt_t  cnt_q  [spmf_pkg::LEVELS];
	spmf_pkg::slot_t head_q [spmf_pkg::LEVELS];
	spmf_pkg::cnt_t  cnt_d  [spmf_pkg::LEVELS];
	spmf_pkg::slot_t head_d [spmf_pkg::LEVELS];

	// Decode
	logic                           accept;
	logic                           is_pop;
	logic                           pri_ok;
	spmf_pkg::lvl_t                 push_lv;
	logic                           push_full;
	logic                           push_ok;
	logic                           pop_any;
	spmf_pkg::lvl_t                 pop_lv;
	logic                           pop_ok;
	logic [spmf_pkg::SUM_W-1:0]     tail_sum;
	spmf_pkg::slot_t                tail_slot;
	spmf_pkg::status_t              status_d;
	logic                           all_empty_d;

	// Tag RAM
	logic                           ram_we;
	logic [spmf_pkg::ADDR_W-1:0]    ram_waddr;
	logic [spmf_pkg::TAG_W-1:0]     ram_wdata;
	logic                           ram_re;
	logic [spmf_pkg::ADDR_W-1:0]    ram_raddr;
	logic [spmf_pkg::TAG_W-1:0]     ram_rdata;

	// Stage 1: waiting for RAM read data
	logic                           valid_s1;
	spmf_pkg::status_t              status_s1;
	logic                           pop_ok_s1;
	logic [spmf_pkg::PRI_W-1:0]     ppri_s1;
	logic                           all_empty_s1;
	logic                           adv_s1;

	// Output register
	logic                           out_valid_q;
	spmf_pkg::status_t              out_status_q;
	logic [spmf_pkg::ID_W-1:0]      out_id_q;
	logic [spmf_pkg::PRI_W-1:0]     out_pri_q;
	logic                           out_empty_q;

	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	always_comb begin
		is_pop  = (req.command == spmf_pkg::CMD_POP);
		pri_ok  = (req.priority_req != '0) &&
			(req.priority_req <= spmf_pkg::PRI_W'(spmf_pkg::LEVELS));
		push_lv = spmf_pkg::LVL_W'(req.priority_req - spmf_pkg::PRI_W'(1));
		push_full = pri_ok && (cnt_q[push_lv] == spmf_pkg::CNT_W'(spmf_pkg::LEVEL_DEPTH));
		push_ok = !is_pop && pri_ok && !push_full;

		// highest non-empty level wins
		pop_any = 1'b0;
		pop_lv  = '0;
		for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
			if (cnt_q[i] != '0) begin
				pop_any = 1'b1;
				pop_lv  = spmf_pkg::LVL_W'(i);
			end
		end
		pop_ok = is_pop && pop_any;

		// tail slot: head + count, wrapped once
		tail_sum = spmf_pkg::SUM_W'(head_q[push_lv]) +
			spmf_pkg::SUM_W'(cnt_q[push_lv][spmf_pkg::SLOT_W-1:0]);
		if (tail_sum >= spmf_pkg::SUM_W'(spmf_pkg::LEVEL_DEPTH)) begin
			tail_sum = tail_sum - spmf_pkg::SUM_W'(spmf_pkg::LEVEL_DEPTH);
		end
		tail_slot = tail_sum[spmf_pkg::SLOT_W-1:0];

		if (is_pop) begin
			status_d = pop_any ? spmf_pkg::ST_OK : spmf_pkg::ST_EMPTY;
		end else if (!pri_ok) begin
			status_d = spmf_pkg::ST_BADPRI;
		end else if (push_full) begin
			status_d = spmf_pkg::ST_FULL;
		end else begin
			status_d = spmf_pkg::ST_OK;
		end

		for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
			cnt_d[i]  = cnt_q[i];
			head_d[i] = head_q[i];
		end
		if (accept && push_ok) begin
			cnt_d[push_lv] = cnt_q[push_lv] + spmf_pkg::CNT_W'(1);
		end
		if (accept && pop_ok) begin
			cnt_d[pop_lv] = cnt_q[pop_lv] - spmf_pkg::CNT_W'(1);
			if (head_q[pop_lv] == spmf_pkg::SLOT_W'(spmf_pkg::LEVEL_DEPTH - 1)) begin
				head_d[pop_lv] = '0;
			end else begin
				head_d[pop_lv] = head_q[pop_lv] + spmf_pkg::SLOT_W'(1);
			end
		end

		all_empty_d = 1'b1;
		for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
			if (cnt_d[i] != '0) begin
				all_empty_d = 1'b0;
			end
		end
	end

	assign ram_we    = accept && push_ok;
	assign ram_waddr = spmf_pkg::ADDR_W'(push_lv) * spmf_pkg::ADDR_W'(spmf_pkg::LEVEL_DEPTH) +
		spmf_pkg::ADDR_W'(tail_slot);
	assign ram_wdata = req.entry_id[spmf_pkg::TAG_W-1:0];
	assign ram_re    = accept && pop_ok;
	assign ram_raddr = spmf_pkg::ADDR_W'(pop_lv) * spmf_pkg::ADDR_W'(spmf_pkg::LEVEL_DEPTH) +
		spmf_pkg::ADDR_W'(head_q[pop_lv]);

	spmf_ram #(
		.WIDTH (spmf_pkg::TAG_W),
		.DEPTH (spmf_pkg::STORE_DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
				cnt_q[i]  <= cnt_d[i];
				head_q[i] <= head_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_d;
			pop_ok_s1    <= pop_ok;
			ppri_s1      <= pop_ok ? spmf_pkg::PRI_W'(pop_lv) + spmf_pkg::PRI_W'(1) : '0;
			all_empty_s1 <= all_empty_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_status_q <= status_s1;
			out_id_q     <= pop_ok_s1 ? spmf_pkg::ID_W'(ram_rdata) : '0;
			out_pri_q    <= ppri_s1;
			out_empty_q  <= all_empty_s1;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.popped_id       = out_id_q;
	assign rsp.popped_priority = out_pri_q;
	assign rsp.all_empty       = out_empty_q;

	// A tag is never written into a level that is already full
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q[push_lv] < spmf_pkg::CNT_W'(spmf_pkg::LEVEL_DEPTH)))
		else $error("tag written into a full level");

	// A pop that found nothing implies the whole queue was empty
	a_empty_pop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == spmf_pkg::ST_EMPTY) |-> rsp.all_empty)
		else $error("empty pop reported with entries held");

	// A successful push leaves at least one entry behind
	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !all_empty_s1)
		else $error("all_empty set after a successful push");

	// Stage 1 stalls only while the output register is held
	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (out_valid_q && !rsp.ready && !req.ready))
		else $error("stage 1 stalled without back-pressure");

	// A successful pop result carries a level in range
	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && pop_ok_s1) |-> (ppri_s1 != '0 &&
			ppri_s1 <= spmf_pkg::PRI_W'(spmf_pkg::LEVELS)))
		else $error("popped level out of range");

endmodule

FILE: test/tb_strict_priority_multilevel_fifo.sv
`timescale 1ns / 1ps
// Testbench for strict_priority_multilevel_fifo: a short directed sequence, then random
// push/pop traffic, checked beat by beat against a queue predictor held in a scoreboard.
// Depends on spmf_pkg, spmf_in_if, spmf_out_if and the block itself.
module tb_strict_priority_multilevel_fifo;

	localparam int RANDOM_ITEMS = 1700;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 10;
	localparam logic [spmf_pkg::ID_W-1:0] TAG_MASK =
		{spmf_pkg::ID_W{1'b1}} >> (spmf_pkg::ID_W - spmf_pkg::TAG_W);

	typedef struct packed {
		spmf_pkg::status_t          status;
		logic [spmf_pkg::ID_W-1:0]  tag;
		logic [spmf_pkg::PRI_W-1:0] level;
		logic                       all_empty;
	} queue_result_t;

	class queue_scoreboard;
		logic [spmf_pkg::ID_W-1:0] tag_ring [spmf_pkg::LEVELS][spmf_pkg::LEVEL_DEPTH];
		int unsigned     fill [spmf_pkg::LEVELS];
		int unsigned     head [spmf_pkg::LEVELS];
		queue_result_t   expected_q [$];
		int unsigned     mismatches;
		int unsigned     results_seen;

		function new();
			foreach (fill[i]) begin
				fill[i] = 0;
				head[i] = 0;
			end
			mismatches = 0;
			results_seen = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Advance the queue state by one accepted command and store its result.
		function void note_command(spmf_pkg::cmd_t cmd, logic [spmf_pkg::PRI_W-1:0] pri,
			logic [spmf_pkg::ID_W-1:0] id);
			queue_result_t r;
			int lv;
			int slot;
			r.status = spmf_pkg::ST_OK;
			r.tag = '0;
			r.level = '0;
			r.all_empty = 1'b1;
			if (cmd == spmf_pkg::CMD_PUSH) begin
				if (pri == 0 || pri > spmf_pkg::LEVELS) begin
					r.status = spmf_pkg::ST_BADPRI;
				end else begin
					lv = pri - 1;
					if (fill[lv] >= spmf_pkg::LEVEL_DEPTH) begin
						r.status = spmf_pkg::ST_FULL;
					end else begin
						slot = (head[lv] + fill[lv]) % spmf_pkg::LEVEL_DEPTH;
						tag_ring[lv][slot] = id & TAG_MASK;
						fill[lv]++;
					end
				end
			end else begin
				lv = -1;
				for (int i = spmf_pkg::LEVELS - 1; i >= 0; i--)
					if (lv < 0 && fill[i] != 0)
						lv = i;
				if (lv < 0) begin
					r.status = spmf_pkg::ST_EMPTY;
				end else begin
					r.tag = tag_ring[lv][head[lv]];
					r.level = spmf_pkg::PRI_W'(lv + 1);
					head[lv] = (head[lv] + 1) % spmf_pkg::LEVEL_DEPTH;
					fill[lv]--;
				end
			end
			foreach (fill[i])
				if (fill[i] != 0)
					r.all_empty = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		endfunction

		function void check_result(logic [spmf_pkg::ST_W-1:0] st,
			logic [spmf_pkg::ID_W-1:0] id, logic [spmf_pkg::PRI_W-1:0] pri, logic empty);
			queue_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing outstanding, expected none actual %0h",
					$time, st);
				return;
			end
			want = expected_q.pop_front();
			if (st !== want.status)
				report("status", want.status, st);
			if (id !== want.tag)
				report("popped_id", want.tag, id);
			if (pri !== want.level)
				report("popped_priority", want.level, pri);
			if (empty !== want.all_empty)
				report("all_empty", want.all_empty, empty);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	queue_scoreboard sb;

	spmf_in_if  cmd_ch ();
	spmf_out_if result_ch ();

	strict_priority_multilevel_fifo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd_ch),
		.rsp    (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one beat after the given gap and hold it until accepted.
	task automatic send_command(spmf_pkg::cmd_t cmd, logic [spmf_pkg::PRI_W-1:0] pri,
		logic [spmf_pkg::ID_W-1:0] id, int gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= cmd;
		cmd_ch.priority_req <= pri;
		cmd_ch.entry_id <= id;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sb.note_command(cmd, pri, id);
	endtask

	task automatic run_directed();
		send_command(spmf_pkg::CMD_POP, 4'd0, 16'h0000, 0);
		send_command(spmf_pkg::CMD_PUSH, 4'd0, 16'h1234, 0);
		send_command(spmf_pkg::CMD_PUSH, spmf_pkg::PRI_W'(spmf_pkg::LEVELS + 1), 16'hFFFF, 0);
		send_command(spmf_pkg::CMD_PUSH, 4'd15, 16'h8001, 1);
		send_command(spmf_pkg::CMD_PUSH, 4'd1, 16'h0000, 0);
		send_command(spmf_pkg::CMD_PUSH, spmf_pkg::PRI_W'(spmf_pkg::LEVELS), 16'hFFFF, 0);
		send_command(spmf_pkg::CMD_PUSH, 4'd4, 16'hAAAA, 2);
		send_command(spmf_pkg::CMD_PUSH, 4'd4, 16'h5555, 0);
		send_command(spmf_pkg::CMD_PUSH, spmf_pkg::PRI_W'(spmf_pkg::LEVELS), 16'h0001, 0);
		// pop fields carry junk on purpose: the block must ignore them
		send_command(spmf_pkg::CMD_POP, 4'd15, 16'hFFFF, 0);
		send_command(spmf_pkg::CMD_POP, 4'd0, 16'h0000, 0);
		send_command(spmf_pkg::CMD_POP, 4'd3, 16'hBEEF, 1);
		send_command(spmf_pkg::CMD_POP, 4'd9, 16'h7FFF, 0);
		send_command(spmf_pkg::CMD_POP, 4'd1, 16'h8000, 0);
		send_command(spmf_pkg::CMD_POP, 4'd8, 16'h0F0F, 0);
		send_command(spmf_pkg::CMD_PUSH, 4'd2, 16'hC3C3, 0);
		send_command(spmf_pkg::CMD_POP, 4'd2, 16'h3C3C, 0);
	endtask

	task automatic run_random();
		int sent;
		int seg;
		int len;
		int push_pct;
		int lo;
		int hi;
		int lv;
		int b;
		bit quiet;
		logic [spmf_pkg::PRI_W-1:0] pri;
		sent = 0;
		seg = 0;
		// overfill one level, then drain past empty
		lv = $urandom_range(1, spmf_pkg::LEVELS);
		repeat (spmf_pkg::LEVEL_DEPTH + 3)
			send_command(spmf_pkg::CMD_PUSH, spmf_pkg::PRI_W'(lv),
				spmf_pkg::ID_W'($urandom_range(0, 65535)), pick_gap(0));
		repeat (spmf_pkg::LEVEL_DEPTH + 2)
			send_command(spmf_pkg::CMD_POP, spmf_pkg::PRI_W'($urandom_range(0, 15)),
				spmf_pkg::ID_W'($urandom_range(0, 65535)), pick_gap(0));
		sent = 2 * spmf_pkg::LEVEL_DEPTH + 5;
		while (sent < RANDOM_ITEMS) begin
			seg++;
			if (seg == 8) begin
				// drop valid and let every outstanding result drain
				cmd_ch.valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			len = $urandom_range(10, 80);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 20;
				default: push_pct = 55;
			endcase
			if ($urandom_range(0, 1)) begin
				lo = $urandom_range(1, spmf_pkg::LEVELS);
				hi = lo + $urandom_range(0, 2);
				if (hi > spmf_pkg::LEVELS)
					hi = spmf_pkg::LEVELS;
			end else begin
				lo = 1;
				hi = spmf_pkg::LEVELS;
			end
			quiet = ($urandom_range(0, 4) == 0);
			repeat (len) begin
				if ($urandom_range(0, 99) < push_pct) begin
					if ($urandom_range(0, 15) == 0) begin
						b = $urandom_range(spmf_pkg::LEVELS, 15);
						pri = (b == spmf_pkg::LEVELS) ? '0 : spmf_pkg::PRI_W'(b);
					end else begin
						pri = spmf_pkg::PRI_W'($urandom_range(lo, hi));
					end
					send_command(spmf_pkg::CMD_PUSH, pri,
						spmf_pkg::ID_W'($urandom_range(0, 65535)), pick_gap(quiet));
				end else begin
					send_command(spmf_pkg::CMD_POP, spmf_pkg::PRI_W'($urandom_range(0, 15)),
						spmf_pkg::ID_W'($urandom_range(0, 65535)), pick_gap(quiet));
				end
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= spmf_pkg::CMD_PUSH;
		cmd_ch.priority_req <= '0;
		cmd_ch.entry_id <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : result_sink
		int gap;
		int stretch;
		bit quiet;
		bit held_off;
		result_ch.ready <= 1'b0;
		stretch = 0;
		quiet = 1'b0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stretch == 0) begin
				stretch = $urandom_range(20, 150);
				quiet = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			// hold off once for a long stretch so the block backs up into its input
			if (!held_off && sb.results_seen >= HOLD_AT) begin
				held_off = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				gap = pick_gap(quiet);
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			sb.check_result(result_ch.status, result_ch.popped_id, result_ch.popped_priority,
				result_ch.all_empty);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				idle = 0;
			else
				idle++;
			if (idle >= STALL_LIMIT) begin
				$display("%0t: no beat on either channel for %0d cycles", $time, idle);
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule

FILE: filelist.f
src/spmf_pkg.sv
src/spmf_in_if.sv
src/spmf_out_if.sv
src/spmf_ram.sv
src/strict_priority_multilevel_fifo.sv
test/tb_strict_priority_multilevel_fifo.sv
